// ===== hdl/rkss_pkg.sv =====
// shared constants and types for the range k-smallest sum versus maximum unit
package rkss_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int MAX_GROUP  = 10;
    localparam int LIST_LEN   = MAX_GROUP - 1;
    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int VAL_W      = 30;
    localparam int IDX_W      = 10;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LR_W       = NODE_W + 1;
    localparam int CNT_W      = $clog2(LIST_LEN + 1);
    localparam int SUM_W      = 34;
    localparam int K_W        = 4;
    localparam int LEN_W      = IDX_W + 1;

    localparam logic [VAL_W-1:0] EMPTY_MARK = VAL_W'(1000000001);
    localparam logic [K_W-1:0]   K_MIN      = K_W'(2);
    localparam logic [K_W-1:0]   K_MAX      = K_W'(MAX_GROUP);
    localparam logic [K_W-1:0]   K_RESET    = K_W'(3);

    typedef enum logic {OP_SET = 1'b0, OP_QUERY = 1'b1} op_t;

    typedef logic [LIST_LEN-1:0][VAL_W-1:0] list_t;

endpackage

// ===== hdl/rkss_merge.sv =====
// merge unit: keeps the smallest entries of two sorted lists, one compare per cycle
module rkss_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  rkss_pkg::list_t     list_a,
    input  rkss_pkg::list_t     list_b,
    output logic                done,
    output rkss_pkg::list_t     result
);

    rkss_pkg::list_t                 a_reg;
    rkss_pkg::list_t                 b_reg;
    rkss_pkg::list_t                 out_reg;
    logic [rkss_pkg::CNT_W-1:0]      cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic                            take_a;
    logic [rkss_pkg::VAL_W-1:0]      pick;

    assign take_a = a_reg[0] < b_reg[0];
    assign pick   = take_a ? a_reg[0] : b_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= list_a;
                b_reg    <= list_b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                out_reg <= {pick, out_reg[rkss_pkg::LIST_LEN-1:1]};
                if (take_a) begin
                    a_reg <= {rkss_pkg::EMPTY_MARK, a_reg[rkss_pkg::LIST_LEN-1:1]};
                end else begin
                    b_reg <= {rkss_pkg::EMPTY_MARK, b_reg[rkss_pkg::LIST_LEN-1:1]};
                end
                if (cnt_reg == rkss_pkg::CNT_W'(rkss_pkg::LIST_LEN - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

// ===== hdl/range_k_smallest_sum_vs_max_unit.sv =====
// top level: segment tree of k-smallest lists and maxima with set-leaf and range query
//
// After reset the unit sweeps all 2048 nodes of its memories once, one node per cycle,
// and takes no word meanwhile (configuration writes are taken). One word is worked at a time.
// A set-leaf word writes its leaf, then for each of 10 ancestor levels reads the sibling,
// merges it in the shared merge unit, which keeps nine sorted entries at one compare per
// cycle, and writes the parent. A query merges each covering node (up to about 20 nodes)
// while climbing the tree level by level, then sums the smallest entries and presents the
// result, the node memory giving one node per read. The group size register is read at
// query time.
module range_k_smallest_sum_vs_max_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [3:0]  cfg_wdata,   // group_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // leaf_index, leaf_value, range_lo, range_hi, zero fill
    input  logic        s_tuser,     // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata      // smallest_sum, range_maximum, sum_exceeds_max, zero fill
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_U_WRITE, ST_U_LOAD, ST_U_MERGE,
        ST_Q_STEP, ST_Q_LOAD, ST_Q_MERGE, ST_Q_SUM, ST_Q_DONE
    } state_t;

    state_t                           state_reg;
    logic [rkss_pkg::K_W-1:0]         group_size_reg;
    logic [rkss_pkg::K_W-1:0]         k_reg;
    logic [rkss_pkg::NODE_W-1:0]      clr_cnt_reg;
    logic [rkss_pkg::NODE_W-1:0]      node_reg;
    logic [rkss_pkg::LR_W-1:0]        l_reg;
    logic [rkss_pkg::LR_W-1:0]        r_reg;
    logic [rkss_pkg::LEN_W-1:0]       len_reg;
    rkss_pkg::list_t                  acc_reg;
    logic [rkss_pkg::VAL_W-1:0]       mx_reg;
    logic [rkss_pkg::SUM_W-1:0]       sum_reg;
    logic [rkss_pkg::CNT_W-1:0]       cnt_reg;
    logic                             m_tvalid_reg;
    logic [71:0]                      m_tdata_reg;

    rkss_pkg::list_t                  list_mem [rkss_pkg::NODE_COUNT];
    logic [rkss_pkg::VAL_W-1:0]       max_mem  [rkss_pkg::NODE_COUNT];
    rkss_pkg::list_t                  rd_list_reg;
    logic [rkss_pkg::VAL_W-1:0]       rd_max_reg;

    logic                             mem_we;
    logic [rkss_pkg::NODE_W-1:0]      mem_waddr;
    rkss_pkg::list_t                  mem_wlist;
    logic [rkss_pkg::VAL_W-1:0]       mem_wmax;
    logic [rkss_pkg::NODE_W-1:0]      rd_addr;
    logic [rkss_pkg::LR_W-1:0]        r_dec;

    logic                             merge_start;
    logic                             merge_done;
    rkss_pkg::list_t                  merge_result;

    logic [rkss_pkg::IDX_W-1:0]       in_idx;
    logic [rkss_pkg::VAL_W-1:0]       in_val;
    logic [rkss_pkg::IDX_W-1:0]       in_lo;
    logic [rkss_pkg::IDX_W-1:0]       in_hi;
    logic [rkss_pkg::IDX_W:0]         q_lo;
    logic [rkss_pkg::IDX_W:0]         q_hi;
    logic [rkss_pkg::IDX_W:0]         s_lo;
    logic [rkss_pkg::IDX_W:0]         s_hi;
    rkss_pkg::list_t                  empty_list;
    rkss_pkg::list_t                  leaf_list;
    logic [rkss_pkg::VAL_W-1:0]       new_max;
    logic                             flag;

    assign in_idx = s_tdata[9:0];
    assign in_val = s_tdata[39:10];
    assign in_lo  = s_tdata[49:40];
    assign in_hi  = s_tdata[59:50];

    always_comb begin
        empty_list = {rkss_pkg::LIST_LEN{rkss_pkg::EMPTY_MARK}};
        leaf_list = empty_list;
        leaf_list[0] = in_val;
        s_lo = (in_lo > in_hi) ? {1'b0, in_hi} : {1'b0, in_lo};
        s_hi = (in_lo > in_hi) ? {1'b0, in_lo} : {1'b0, in_hi};
        q_lo = (s_lo >= (rkss_pkg::IDX_W+1)'(rkss_pkg::LEAF_COUNT))
             ? (rkss_pkg::IDX_W+1)'(rkss_pkg::LEAF_COUNT - 1) : s_lo;
        q_hi = (s_hi >= (rkss_pkg::IDX_W+1)'(rkss_pkg::LEAF_COUNT))
             ? (rkss_pkg::IDX_W+1)'(rkss_pkg::LEAF_COUNT - 1) : s_hi;
    end

    assign new_max = (rd_max_reg > mx_reg) ? rd_max_reg : mx_reg;
    assign flag    = (len_reg < rkss_pkg::LEN_W'(k_reg))
                   || (sum_reg > rkss_pkg::SUM_W'(mx_reg));
    assign r_dec   = r_reg - 1'b1;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = node_reg;
        mem_wlist = acc_reg;
        mem_wmax  = mx_reg;
        rd_addr   = r_dec[rkss_pkg::NODE_W-1:0];
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wlist = empty_list;
                mem_wmax  = '0;
            end
            ST_U_WRITE: begin
                mem_we  = 1'b1;
                rd_addr = node_reg ^ rkss_pkg::NODE_W'(1);
            end
            ST_Q_STEP: begin
                rd_addr = l_reg[0] ? l_reg[rkss_pkg::NODE_W-1:0]
                                   : r_dec[rkss_pkg::NODE_W-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            list_mem[mem_waddr] <= mem_wlist;
            max_mem[mem_waddr]  <= mem_wmax;
        end
        rd_list_reg <= list_mem[rd_addr];
        rd_max_reg  <= max_mem[rd_addr];
    end

    assign merge_start = (state_reg == ST_U_LOAD) || (state_reg == ST_Q_LOAD);

    rkss_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (merge_start),
        .list_a  (acc_reg),
        .list_b  (rd_list_reg),
        .done    (merge_done),
        .result  (merge_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            group_size_reg <= rkss_pkg::K_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wen) begin
                group_size_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_Q_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == rkss_pkg::NODE_W'(rkss_pkg::NODE_COUNT - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == rkss_pkg::OP_SET) begin
                            acc_reg  <= leaf_list;
                            mx_reg   <= in_val;
                            node_reg <= rkss_pkg::NODE_W'(in_idx) +
                                        rkss_pkg::NODE_W'(rkss_pkg::LEAF_COUNT);
                            if ((rkss_pkg::IDX_W+1)'(in_idx) <
                                (rkss_pkg::IDX_W+1)'(rkss_pkg::LEAF_COUNT)) begin
                                state_reg <= ST_U_WRITE;
                            end
                        end else begin
                            acc_reg   <= empty_list;
                            mx_reg    <= '0;
                            len_reg   <= rkss_pkg::LEN_W'(q_hi - q_lo) + 1'b1;
                            l_reg     <= rkss_pkg::LR_W'(q_lo) +
                                         rkss_pkg::LR_W'(rkss_pkg::LEAF_COUNT);
                            r_reg     <= rkss_pkg::LR_W'(q_hi) +
                                         rkss_pkg::LR_W'(rkss_pkg::LEAF_COUNT + 1);
                            if (group_size_reg < rkss_pkg::K_MIN) begin
                                k_reg <= rkss_pkg::K_MIN;
                            end else if (group_size_reg > rkss_pkg::K_MAX) begin
                                k_reg <= rkss_pkg::K_MAX;
                            end else begin
                                k_reg <= group_size_reg;
                            end
                            state_reg <= ST_Q_STEP;
                        end
                    end
                end
                ST_U_WRITE: begin
                    if (node_reg == rkss_pkg::NODE_W'(1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_U_LOAD;
                    end
                end
                ST_U_LOAD: begin
                    mx_reg    <= new_max;
                    node_reg  <= node_reg >> 1;
                    state_reg <= ST_U_MERGE;
                end
                ST_U_MERGE: begin
                    if (merge_done) begin
                        acc_reg   <= merge_result;
                        state_reg <= ST_U_WRITE;
                    end
                end
                ST_Q_STEP: begin
                    if (l_reg >= r_reg) begin
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_Q_SUM;
                    end else if (l_reg[0]) begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= ST_Q_LOAD;
                    end else if (r_reg[0]) begin
                        r_reg     <= r_dec;
                        state_reg <= ST_Q_LOAD;
                    end else begin
                        l_reg <= l_reg >> 1;
                        r_reg <= r_reg >> 1;
                    end
                end
                ST_Q_LOAD: begin
                    mx_reg    <= new_max;
                    state_reg <= ST_Q_MERGE;
                end
                ST_Q_MERGE: begin
                    if (merge_done) begin
                        acc_reg   <= merge_result;
                        state_reg <= ST_Q_STEP;
                    end
                end
                ST_Q_SUM: begin
                    if (rkss_pkg::K_W'(cnt_reg) + 1'b1 < k_reg) begin
                        sum_reg <= sum_reg + rkss_pkg::SUM_W'(acc_reg[0]);
                    end
                    acc_reg <= {rkss_pkg::EMPTY_MARK, acc_reg[rkss_pkg::LIST_LEN-1:1]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == rkss_pkg::CNT_W'(rkss_pkg::LIST_LEN - 1)) begin
                        state_reg <= ST_Q_DONE;
                    end
                end
                ST_Q_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {7'd0, flag, mx_reg, sum_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
